@@ rtl/core/dsts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsts_pkg
// Types, character codes and unit tables shared by the duration parser.
// ----------------------------------------------------------------------------
package dsts_pkg;

	localparam int SEC_W    = 63;
	localparam int WEIGHT_W = 25;

	// unit index: 0 = Y ... 6 = s, 7 = none / all units taken
	typedef logic [2:0] unit_idx_t;

	localparam unit_idx_t UNIT_NONE = 3'd7;
	localparam unit_idx_t UNIT_DONE = 3'd7;
	localparam unit_idx_t UNIT_Y    = 3'd0;
	localparam unit_idx_t UNIT_MON  = 3'd1;
	localparam unit_idx_t UNIT_W    = 3'd2;
	localparam unit_idx_t UNIT_D    = 3'd3;
	localparam unit_idx_t UNIT_H    = 3'd4;
	localparam unit_idx_t UNIT_MIN  = 3'd5;
	localparam unit_idx_t UNIT_S    = 3'd6;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_Y    = 8'h59;
	localparam logic [7:0] CH_MON  = 8'h4D;
	localparam logic [7:0] CH_W    = 8'h57;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_H    = 8'h68;
	localparam logic [7:0] CH_MIN  = 8'h6D;
	localparam logic [7:0] CH_S    = 8'h73;

	// one character request
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_t;

	// one parse result
	typedef struct packed {
		logic [SEC_W-1:0] seconds;
		logic             parse_error;
	} result_t;

	// work handed from the front to the back
	typedef struct packed {
		logic             has_unit;
		unit_idx_t        unit;
		logic [SEC_W-1:0] pending;
		logic             is_last;
		logic             front_fail;
		logic             plain;
	} evt_t;

	// unit letter decode
	function automatic unit_idx_t unit_of(input logic [7:0] c);
		unit_idx_t u;
		unique case (c)
			CH_Y:    u = UNIT_Y;
			CH_MON:  u = UNIT_MON;
			CH_W:    u = UNIT_W;
			CH_D:    u = UNIT_D;
			CH_H:    u = UNIT_H;
			CH_MIN:  u = UNIT_MIN;
			CH_S:    u = UNIT_S;
			default: u = UNIT_NONE;
		endcase
		return u;
	endfunction

	// seconds per unit
	function automatic logic [WEIGHT_W-1:0] unit_weight(input unit_idx_t u);
		logic [WEIGHT_W-1:0] w;
		unique case (u)
			UNIT_Y:   w = 25'd31556926;
			UNIT_MON: w = 25'd2592000;
			UNIT_W:   w = 25'd604800;
			UNIT_D:   w = 25'd86400;
			UNIT_H:   w = 25'd3600;
			UNIT_MIN: w = 25'd60;
			UNIT_S:   w = 25'd1;
			default:  w = '0;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/core/duration_string_to_seconds.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_string_to_seconds
// Parses a duration string such as "1D2h30m" into seconds.
// ----------------------------------------------------------------------------
// Characters arrive one per request with the final one flagged; one result
// (seconds or parse_error) leaves per string. One character is taken every
// cycle while the event queue has room; after the final character is taken,
// its event passes through the queue, the three-stage weight multiply and
// accumulate in the back end and then the result register. A stalled result
// holds the back end; the front keeps accepting until the queue of
// QUEUE_DEPTH events fills, and only accepted unit letters and final
// characters use a queue entry.
module duration_string_to_seconds
	import dsts_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    char_valid,
	output logic    char_ready,
	input  char_t   char_item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_item
);

	logic q_full;
	logic q_push;
	evt_t q_evt;
	logic q_pop;
	logic q_not_empty;
	evt_t q_head;

	// character classification
	dsts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_evt      (q_evt)
	);

	// event queue
	dsts_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_evt  (q_evt),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_evt  (q_head)
	);

	// weighting, accumulation and result
	dsts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_item    (res_item)
	);

endmodule

@@ rtl/core/dsts_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsts_front
// Classifies characters, builds the pending number and checks unit order;
// completed unit groups and end-of-string markers go to the queue.
// ----------------------------------------------------------------------------
module dsts_front
	import dsts_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   char_valid,
	output logic   char_ready,
	input  char_t  char_item,
	input  logic   q_full,
	output logic   q_push,
	output evt_t   q_evt
);

	logic [SEC_W-1:0] pend_q;
	logic             seen_q;
	unit_idx_t        next_unit_q;
	logic             fail_q;

	logic             in_fire;
	logic             is_digit;
	logic [3:0]       digit;
	logic [SEC_W+3:0] scaled;
	unit_idx_t        unit;
	logic             fail_now;
	logic             take_digit;
	logic             take_unit;
	logic [SEC_W-1:0] pend_next;
	unit_idx_t        next_unit_next;

	assign char_ready = !q_full;
	assign in_fire    = char_valid && char_ready;

	// digit accumulate: pending * 10 + digit
	always_comb begin
		is_digit = (char_item.char_code >= CH_ZERO) && (char_item.char_code <= CH_NINE);
		digit    = 4'(char_item.char_code - CH_ZERO);
		scaled   = ({4'b0, pend_q} << 3) + ({4'b0, pend_q} << 1) + (SEC_W+4)'(digit);
		unit     = unit_of(char_item.char_code);
	end

	// character classification
	always_comb begin
		fail_now   = 1'b0;
		take_digit = 1'b0;
		take_unit  = 1'b0;
		if (!fail_q) begin
			if (next_unit_q == UNIT_DONE) begin
				fail_now = 1'b1;
			end else if (is_digit) begin
				if (|scaled[SEC_W+3:SEC_W]) begin
					fail_now = 1'b1;
				end else begin
					take_digit = 1'b1;
				end
			end else if (!seen_q || unit == UNIT_NONE || unit < next_unit_q) begin
				fail_now = 1'b1;
			end else begin
				take_unit = 1'b1;
			end
		end
	end

	always_comb begin
		if (take_digit) begin
			pend_next = scaled[SEC_W-1:0];
		end else if (take_unit) begin
			pend_next = '0;
		end else begin
			pend_next = pend_q;
		end
		next_unit_next = take_unit ? unit_idx_t'(unit + 3'd1) : next_unit_q;
	end

	// queue request
	always_comb begin
		q_push           = in_fire && (take_unit || char_item.last_char);
		q_evt.has_unit   = take_unit;
		q_evt.unit       = unit;
		q_evt.pending    = take_unit ? pend_q : pend_next;
		q_evt.is_last    = char_item.last_char;
		q_evt.front_fail = fail_q || fail_now;
		q_evt.plain      = (next_unit_next == UNIT_Y);
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_q      <= 1'b0;
			next_unit_q <= UNIT_Y;
			fail_q      <= 1'b0;
		end else if (in_fire) begin
			if (char_item.last_char) begin
				pend_q      <= '0;
				seen_q      <= 1'b0;
				next_unit_q <= UNIT_Y;
				fail_q      <= 1'b0;
			end else begin
				pend_q      <= pend_next;
				seen_q      <= take_unit ? 1'b0 : (seen_q || is_digit);
				next_unit_q <= next_unit_next;
				fail_q      <= fail_q || fail_now;
			end
		end
	end

endmodule

@@ rtl/core/dsts_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsts_fifo
// Short queue of parse events between the front and the back.
// ----------------------------------------------------------------------------
module dsts_fifo
	import dsts_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  evt_t push_evt,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output evt_t head_evt
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	evt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_evt  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

@@ rtl/core/dsts_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsts_back
// Weights each unit group, accumulates the total with overflow check and
// produces one result per string.
// ----------------------------------------------------------------------------
module dsts_back
	import dsts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_not_empty,
	input  evt_t    q_head,
	output logic    q_pop,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_item
);

	localparam int LO_W   = 32;
	localparam int HI_W   = SEC_W - LO_W;
	localparam int PLO_W  = LO_W + WEIGHT_W;
	localparam int PHI_W  = HI_W + WEIGHT_W;
	localparam int PROD_W = SEC_W + WEIGHT_W;

	logic             adv;

	logic             valid_s1;
	evt_t             evt_s1;
	logic             valid_s2;
	evt_t             evt_s2;
	logic [PLO_W-1:0] plo_s2;
	logic [PHI_W-1:0] phi_s2;
	logic             valid_s3;
	evt_t             evt_s3;
	logic [SEC_W-1:0] prod_s3;
	logic             big_s3;

	logic [SEC_W-1:0] total_q;
	logic             ovf_q;
	logic             res_valid_q;
	result_t          res_q;

	logic [WEIGHT_W-1:0] weight;
	logic [PROD_W-1:0]   prod;
	logic [SEC_W:0]      sum;
	logic                ovf_now;
	logic                err;

	// whole back end moves unless the result register is held
	assign adv   = !(res_valid_q && !res_ready);
	assign q_pop = adv && q_not_empty;

	assign weight = unit_weight(evt_s1.unit);
	assign prod   = {phi_s2, LO_W'(0)} + PROD_W'(plo_s2);
	assign sum    = {1'b0, total_q} + {1'b0, prod_s3};
	assign ovf_now = evt_s3.has_unit && (big_s3 || sum[SEC_W]);
	assign err     = evt_s3.front_fail || ovf_q || ovf_now;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_not_empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// s1 load, s2 partial products, s3 product combine
	always_ff @(posedge clk) begin
		if (adv) begin
			evt_s1  <= q_head;
			evt_s2  <= evt_s1;
			plo_s2  <= PLO_W'(evt_s1.pending[LO_W-1:0]) * PLO_W'(weight);
			phi_s2  <= PHI_W'(evt_s1.pending[SEC_W-1:LO_W]) * PHI_W'(weight);
			evt_s3  <= evt_s2;
			prod_s3 <= prod[SEC_W-1:0];
			big_s3  <= |prod[PROD_W-1:SEC_W];
		end
	end

	// running total and overflow flag, cleared at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else if (adv && valid_s3) begin
			if (evt_s3.is_last) begin
				total_q <= '0;
				ovf_q   <= 1'b0;
			end else if (ovf_now) begin
				ovf_q <= 1'b1;
			end else if (evt_s3.has_unit) begin
				total_q <= sum[SEC_W-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s3 && evt_s3.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3 && evt_s3.is_last) begin
			res_q.parse_error <= err;
			if (err) begin
				res_q.seconds <= '0;
			end else if (evt_s3.plain) begin
				res_q.seconds <= evt_s3.pending;
			end else if (evt_s3.has_unit) begin
				res_q.seconds <= sum[SEC_W-1:0];
			end else begin
				res_q.seconds <= total_q;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the duration string parser.
// ----------------------------------------------------------------------------
// Duration strings go in one character per request; each final character
// yields one result. A table of short strings covers plain numbers, every
// unit letter and the bad-character and unit-order error paths, then random
// strings follow: mostly well-formed unit groups, plus overflowing numbers
// and corrupted strings. Every result is checked against a bit-accurate parser
// model kept here or a typed directed expectation, with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module tb_top
	import dsts_pkg::*;
();

	localparam int         N_CHARS   = 1950;
	localparam int         CYCLE_CAP = 1500000;
	localparam logic [63:0] SEC_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    char_valid = 1'b0;
	logic    char_ready;
	char_t   char_item = '0;
	logic    res_valid;
	logic    res_ready = 1'b0;
	result_t res_item;

	// unit letters and their weights, in the order they must appear
	logic [7:0]  unit_char [7] = '{CH_Y, CH_MON, CH_W, CH_D, CH_H, CH_MIN, CH_S};
	logic [63:0] unit_secs [7] = '{64'd31556926, 64'd2592000, 64'd604800,
		64'd86400, 64'd3600, 64'd60, 64'd1};

	// parser model state
	logic [63:0] dur_pending = '0;
	logic [63:0] dur_total = '0;
	unit_idx_t   dur_next_unit = UNIT_Y;
	bit          dur_digit_seen = 1'b0;
	bit          dur_failed = 1'b0;

	result_t     expected_durations [$];
	logic [7:0]  str_bytes [$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          error_results = 0;
	int          strings_sent = 0;
	int          chars_sent = 0;
	int          cycles = 0;
	int          ready_stall = 0;
	bit          calm = 1'b0;

	// directed strings; typed expectations only where obvious
	typedef struct {
		int              len;
		logic [8*10-1:0] text;
		bit              typed;
		bit              t_err;
		logic [62:0]     t_secs;
	} dir_row_t;

	dir_row_t dir_tab [11] = '{
		'{1, 80'hFF,    1'b1, 1'b1, 63'd0},
		'{1, 80'h00,    1'b1, 1'b1, 63'd0},
		'{1, "7",       1'b1, 1'b0, 63'd7},
		'{4, "1Y2M",    1'b0, 1'b0, 63'd0},
		'{4, "1W2D",    1'b0, 1'b0, 63'd0},
		'{6, "3h4m5s",  1'b0, 1'b0, 63'd0},
		'{3, "2m3",     1'b1, 1'b0, 63'd120},
		'{3, "5s7",     1'b1, 1'b1, 63'd0},
		'{1, "h",       1'b1, 1'b1, 63'd0},
		'{4, "1m1h",    1'b1, 1'b1, 63'd0},
		'{2, "x9",      1'b1, 1'b1, 63'd0}
	};

	duration_string_to_seconds u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// gap length: mostly none or short, now and then long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// parser model: advance by one character, report a result on the last one
	function automatic bit parse_char(input char_t it, output result_t res);
		logic [63:0] d;
		logic [63:0] w;
		unit_idx_t   u;
		res = '0;
		u = UNIT_NONE;
		if (!dur_failed) begin
			if (dur_next_unit == UNIT_DONE) begin
				dur_failed = 1'b1;
			end else if (it.char_code >= CH_ZERO && it.char_code <= CH_NINE) begin
				d = 64'(it.char_code - CH_ZERO);
				dur_digit_seen = 1'b1;
				if (dur_pending > (SEC_MAX - d) / 64'd10)
					dur_failed = 1'b1;
				else
					dur_pending = dur_pending * 64'd10 + d;
			end else begin
				for (int i = 0; i < 7; i++)
					if (it.char_code == unit_char[i])
						u = unit_idx_t'(i);
				if (!dur_digit_seen || u == UNIT_NONE || u < dur_next_unit) begin
					dur_failed = 1'b1;
				end else begin
					w = unit_secs[u];
					if (dur_pending > (SEC_MAX - dur_total) / w) begin
						dur_failed = 1'b1;
					end else begin
						dur_total = dur_total + dur_pending * w;
						dur_pending = '0;
						dur_digit_seen = 1'b0;
						dur_next_unit = u + 3'd1;
					end
				end
			end
		end
		if (!it.last_char)
			return 1'b0;
		res.parse_error = dur_failed;
		if (dur_failed)
			res.seconds = '0;
		else if (dur_next_unit == UNIT_Y)
			res.seconds = dur_pending[62:0];
		else
			res.seconds = dur_total[62:0];
		dur_pending = '0;
		dur_total = '0;
		dur_next_unit = UNIT_Y;
		dur_digit_seen = 1'b0;
		dur_failed = 1'b0;
		return 1'b1;
	endfunction

	// random decimal digits onto the string under construction
	function automatic void append_digits(input int n);
		for (int i = 0; i < n; i++)
			str_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// one character request; entered and left at a falling edge
	task automatic send_char(input char_t it, input bit typed, input result_t typed_res);
		int      gap;
		result_t pred;
		gap = idle_cycles();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		char_item <= it;
		do
			@(posedge clk);
		while (!char_ready);
		if (parse_char(it, pred))
			expected_durations.push_back(typed ? typed_res : pred);
		chars_sent++;
		@(negedge clk);
	endtask

	// result side: random back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else if (ready_stall > 0) begin
			ready_stall <= ready_stall - 1;
			res_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			ready_stall <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 2);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (res_item.parse_error)
				error_results++;
			if (expected_durations.size() == 0) begin
				$display("%0t: unexpected result seconds %0d parse_error %0b", $time,
					res_item.seconds, res_item.parse_error);
				mismatches++;
			end else begin
				want = expected_durations.pop_front();
				if (res_item.seconds !== want.seconds) begin
					$display("%0t: seconds expected %0d actual %0d", $time,
						want.seconds, res_item.seconds);
					mismatches++;
				end
				if (res_item.parse_error !== want.parse_error) begin
					$display("%0t: parse_error expected %0b actual %0b", $time,
						want.parse_error, res_item.parse_error);
					mismatches++;
				end
			end
		end
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_durations.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus
	initial begin
		char_t   it;
		result_t tres;
		string   lit;
		int      kind;
		int      r;
		int      pos;
		int      next_drain;
		bit      any;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed strings
		foreach (dir_tab[k]) begin
			for (int i = 0; i < dir_tab[k].len; i++) begin
				it.char_code = dir_tab[k].text[8*(dir_tab[k].len-1-i) +: 8];
				it.last_char = (i == dir_tab[k].len - 1);
				tres.seconds = dir_tab[k].t_secs;
				tres.parse_error = dir_tab[k].t_err;
				send_char(it, dir_tab[k].typed, tres);
			end
			strings_sent++;
		end

		// hold off until the directed results are all back
		char_valid <= 1'b0;
		@(negedge clk);
		while (expected_durations.size() != 0)
			@(negedge clk);

		// random strings
		next_drain = chars_sent + 500;
		while (chars_sent < N_CHARS) begin
			str_bytes.delete();
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				// plain seconds, sometimes right at the 63-bit limit
				r = $urandom_range(0, 9);
				if (r < 2) begin
					lit = (r == 0) ? "9223372036854775807" : "9223372036854775808";
					for (int i = 0; i < lit.len(); i++)
						str_bytes.push_back(lit[i]);
				end else if (r < 4) begin
					append_digits($urandom_range(17, 20));
				end else begin
					append_digits($urandom_range(1, 6));
				end
			end else begin
				// ordered unit groups, a few with huge counts
				any = 1'b0;
				for (int u = 0; u < 7; u++) begin
					if ($urandom_range(0, 1) == 1 || (u == 6 && !any)) begin
						append_digits(($urandom_range(0, 19) == 0) ? $urandom_range(7, 12)
							: $urandom_range(1, 3));
						str_bytes.push_back(unit_char[u]);
						any = 1'b1;
					end
				end
				if ($urandom_range(0, 4) == 0)
					append_digits($urandom_range(1, 3));
				// corrupt those drawn with kind 75 or more, a quarter of all strings
				if (kind >= 75) begin
					pos = $urandom_range(0, str_bytes.size() - 1);
					case ($urandom_range(0, 3))
						0: str_bytes[pos] = 8'($urandom_range(0, 255));
						1: str_bytes.insert(pos, unit_char[$urandom_range(0, 6)]);
						2: str_bytes.delete(pos);
						default: str_bytes.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end
			if ($urandom_range(0, 24) == 0)
				calm <= !calm;
			foreach (str_bytes[i]) begin
				it.char_code = str_bytes[i];
				it.last_char = (i == str_bytes.size() - 1);
				send_char(it, 1'b0, '0);
			end
			strings_sent++;
			if (chars_sent >= next_drain) begin
				next_drain = chars_sent + 500;
				char_valid <= 1'b0;
				@(negedge clk);
				while (expected_durations.size() != 0)
					@(negedge clk);
			end
		end

		// drain
		char_valid <= 1'b0;
		@(negedge clk);
		while (expected_durations.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d strings in %0d characters: %0d results, %0d of them errors",
			strings_sent, chars_sent, results_seen, error_results);
		$display("%0d field mismatches", mismatches);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/dsts_pkg.sv
rtl/core/dsts_front.sv
rtl/core/dsts_fifo.sv
rtl/core/dsts_back.sv
rtl/core/duration_string_to_seconds.sv
test/tb_top.sv
